// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define CDQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    localparam addr_t LAST_IDX = addr_t'(DEPTH - 1);

    function automatic addr_t idx_next(input addr_t i);
        return (i == LAST_IDX) ? '0 : addr_t'(i + addr_t'(1));
    endfunction

    function automatic addr_t idx_prev(input addr_t i);
        return (i == '0) ? LAST_IDX : addr_t'(i - addr_t'(1));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/circular_deque_core.sv =====
// circular_deque_core: double-ended queue of 32-bit signed words held in a
// single-port-write, single-port-read synchronous RAM of cdq_pkg::DEPTH entries.
//
// Command channel: an operation (op, push_value) transfers on a rising edge
// with start high and busy low. op selects push front, push rear, pop front
// or pop rear.
// Result channel: done pulses for exactly one cycle, the cycle right after the
// command transfer, with status, pop_value, is_empty and is_full valid in it.
// The receiver cannot stall; it must take the result in that cycle.
// busy is high during the result cycle, so a new command cannot transfer
// until the result of the last one has been presented; a popped word comes
// from a registered read of the RAM.
// Reset empties the deque (head and tail at zero) and clears done and busy.
// RAM contents are not cleared; only written entries are ever read back.
`default_nettype none

`include "assert_macros.svh"

module circular_deque_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          op,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]   push_value,
    output logic                                     done,
    output logic [1:0]                               status,
    output logic signed [cdq_pkg::DATA_W-1:0]        pop_value,
    output logic                                     is_empty,
    output logic                                     is_full
);

    logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];

    cdq_pkg::addr_t     head_reg, head_next;
    cdq_pkg::addr_t     tail_reg, tail_next;
    logic               empty_reg, empty_next;
    logic               full_reg, full_next;
    logic               busy_reg;
    logic               done_reg;
    cdq_pkg::status_t   status_reg, status_next;
    logic               pop_ok_reg, pop_ok_next;
    logic [cdq_pkg::DATA_W-1:0] rd_data_reg;

    logic               accept;
    logic               cur_full;
    logic               we, re;
    cdq_pkg::addr_t     waddr, raddr;

    assign accept   = start && !busy_reg;
    assign cur_full = !empty_reg && (head_reg == cdq_pkg::idx_next(tail_reg));

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = cdq_pkg::ST_OK;
        pop_ok_next = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = '0;
        raddr       = head_reg;
        unique case (cdq_pkg::op_t'(op))
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR:
            begin
                if (cur_full)
                begin
                    status_next = cdq_pkg::ST_OVERFLOW;
                end
                else if (empty_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    we         = accept;
                    waddr      = '0;
                end
                else if (cdq_pkg::op_t'(op) == cdq_pkg::OP_PUSH_FRONT)
                begin
                    head_next = cdq_pkg::idx_prev(head_reg);
                    we        = accept;
                    waddr     = head_next;
                end
                else
                begin
                    tail_next = cdq_pkg::idx_next(tail_reg);
                    we        = accept;
                    waddr     = tail_next;
                end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR:
            begin
                if (empty_reg)
                begin
                    status_next = cdq_pkg::ST_UNDERFLOW;
                end
                else if (head_reg == tail_reg)
                begin
                    raddr       = head_reg;
                    re          = accept;
                    pop_ok_next = 1'b1;
                    head_next   = '0;
                    tail_next   = '0;
                    empty_next  = 1'b1;
                end
                else if (cdq_pkg::op_t'(op) == cdq_pkg::OP_POP_FRONT)
                begin
                    raddr       = head_reg;
                    re          = accept;
                    pop_ok_next = 1'b1;
                    head_next   = cdq_pkg::idx_next(head_reg);
                end
                else
                begin
                    raddr       = tail_reg;
                    re          = accept;
                    pop_ok_next = 1'b1;
                    tail_next   = cdq_pkg::idx_prev(tail_reg);
                end
            end
            default:
            begin
                status_next = cdq_pkg::ST_OK;
            end
        endcase
        full_next = !empty_next && (head_next == cdq_pkg::idx_next(tail_next));
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= push_value;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            empty_reg  <= 1'b1;
            full_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= cdq_pkg::ST_OK;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= accept;
            if (accept)
            begin
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                empty_reg  <= empty_next;
                full_reg   <= full_next;
                status_reg <= status_next;
                pop_ok_reg <= pop_ok_next;
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign pop_value = pop_ok_reg ? $signed(rd_data_reg) : '0;
    assign is_empty  = empty_reg;
    assign is_full   = full_reg;

    `CDQ_ASSERT(a_not_empty_and_full, !(empty_reg && full_reg), "deque both empty and full")
    `CDQ_ASSERT_NEXT(a_result_follows, accept, done_reg, "no result after transfer")
    `CDQ_ASSERT(a_empty_ptrs_zero, empty_reg |-> (head_reg == '0 && tail_reg == '0), "empty deque with nonzero pointers")
    `CDQ_ASSERT(a_underflow_clean, (done_reg && status_reg == cdq_pkg::ST_UNDERFLOW) |-> (pop_value == '0 && empty_reg), "underflow result not clean")
    `CDQ_ASSERT_NEXT(a_no_back_to_back, done_reg, !done_reg, "result strobe held two cycles")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_OPS   = 360;
    localparam int DIR_ROWS     = 22;

    typedef struct {
        cdq_pkg::status_t           st;
        logic [cdq_pkg::DATA_W-1:0] pv;
        logic                       emp;
        logic                       ful;
    } deque_res_t;

    typedef struct {
        cdq_pkg::op_t               op;
        logic [cdq_pkg::DATA_W-1:0] val;
        bit                         fixed;
        deque_res_t                 res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] op = 2'd0;
    logic signed [cdq_pkg::DATA_W-1:0] push_value = '0;
    logic busy;
    logic done;
    logic [1:0] status;
    logic signed [cdq_pkg::DATA_W-1:0] pop_value;
    logic is_empty;
    logic is_full;

    logic [cdq_pkg::DATA_W-1:0] shadow_store [cdq_pkg::DEPTH];
    int sh_head = 0;
    int sh_tail = 0;
    bit sh_empty = 1'b1;

    deque_res_t pending_results [$];
    deque_res_t no_res;
    int mismatch_count = 0;
    bit burst_mode = 1'b0;
    dir_row_t dir_tbl [DIR_ROWS];

    circular_deque_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .push_value (push_value),
        .done       (done),
        .status     (status),
        .pop_value  (pop_value),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit shadow_full();
        return !sh_empty && (sh_head == (sh_tail + 1) % cdq_pkg::DEPTH);
    endfunction

    function automatic deque_res_t predict_deque_op(cdq_pkg::op_t o,
                                                    logic [cdq_pkg::DATA_W-1:0] v);
        deque_res_t r;
        r.st = cdq_pkg::ST_OK;
        r.pv = '0;
        if (o == cdq_pkg::OP_PUSH_FRONT || o == cdq_pkg::OP_PUSH_REAR)
        begin
            if (shadow_full())
                r.st = cdq_pkg::ST_OVERFLOW;
            else if (sh_empty)
            begin
                sh_head = 0;
                sh_tail = 0;
                shadow_store[0] = v;
                sh_empty = 1'b0;
            end
            else if (o == cdq_pkg::OP_PUSH_FRONT)
            begin
                sh_head = (sh_head + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                shadow_store[sh_head] = v;
            end
            else
            begin
                sh_tail = (sh_tail + 1) % cdq_pkg::DEPTH;
                shadow_store[sh_tail] = v;
            end
        end
        else
        begin
            if (sh_empty)
                r.st = cdq_pkg::ST_UNDERFLOW;
            else if (sh_head == sh_tail)
            begin
                r.pv = shadow_store[sh_head];
                sh_head = 0;
                sh_tail = 0;
                sh_empty = 1'b1;
            end
            else if (o == cdq_pkg::OP_POP_FRONT)
            begin
                r.pv = shadow_store[sh_head];
                sh_head = (sh_head + 1) % cdq_pkg::DEPTH;
            end
            else
            begin
                r.pv = shadow_store[sh_tail];
                sh_tail = (sh_tail + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
            end
        end
        r.emp = sh_empty;
        r.ful = shadow_full();
        return r;
    endfunction

    function automatic dir_row_t chk(cdq_pkg::op_t o, logic [cdq_pkg::DATA_W-1:0] v);
        dir_row_t d;
        d.op = o;
        d.val = v;
        d.fixed = 1'b0;
        d.res = no_res;
        return d;
    endfunction

    function automatic dir_row_t fix(cdq_pkg::op_t o, logic [cdq_pkg::DATA_W-1:0] v,
                                     cdq_pkg::status_t s,
                                     logic [cdq_pkg::DATA_W-1:0] pv, logic e, logic f);
        dir_row_t d;
        d.op = o;
        d.val = v;
        d.fixed = 1'b1;
        d.res.st = s;
        d.res.pv = pv;
        d.res.emp = e;
        d.res.ful = f;
        return d;
    endfunction

    function automatic logic [cdq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::op_t pick_op(int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic issue_op(cdq_pkg::op_t o, logic [cdq_pkg::DATA_W-1:0] v, bit use_fixed,
                            deque_res_t fixed_res);
        int gap;
        deque_res_t r;
        gap = burst_mode ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        op <= o;
        push_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_deque_op(o, v);
        pending_results.push_back(use_fixed ? fixed_res : r);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing expected: status %0d pop_value %h",
                         $time, status, pop_value);
            end
            else
            begin
                deque_res_t e;
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                end
                if (pop_value !== e.pv)
                begin
                    mismatch_count++;
                    $display("%0t: pop_value expected %h actual %h", $time, e.pv, pop_value);
                end
                if (is_empty !== e.emp)
                begin
                    mismatch_count++;
                    $display("%0t: is_empty expected %b actual %b", $time, e.emp, is_empty);
                end
                if (is_full !== e.ful)
                begin
                    mismatch_count++;
                    $display("%0t: is_full expected %b actual %b", $time, e.ful, is_full);
                end
            end
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int push_pct;
        no_res.st = cdq_pkg::ST_OK;
        no_res.pv = '0;
        no_res.emp = 1'b0;
        no_res.ful = 1'b0;

        dir_tbl = '{
            fix(cdq_pkg::OP_POP_FRONT,  32'h1111_1111, cdq_pkg::ST_UNDERFLOW, '0, 1'b1, 1'b0),
            fix(cdq_pkg::OP_POP_REAR,   32'h2222_2222, cdq_pkg::ST_UNDERFLOW, '0, 1'b1, 1'b0),
            fix(cdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, cdq_pkg::ST_OK, '0, 1'b0, 1'b0),
            fix(cdq_pkg::OP_POP_REAR,   32'h0000_0000, cdq_pkg::ST_OK, 32'h7fff_ffff,
                1'b1, 1'b0),
            fix(cdq_pkg::OP_PUSH_REAR,  32'h8000_0000, cdq_pkg::ST_OK, '0, 1'b0, 1'b0),
            fix(cdq_pkg::OP_POP_FRONT,  32'hffff_ffff, cdq_pkg::ST_OK, 32'h8000_0000,
                1'b1, 1'b0),
            chk(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000),
            chk(cdq_pkg::OP_PUSH_FRONT, 32'hffff_ffff),   // head wraps below zero
            chk(cdq_pkg::OP_PUSH_REAR,  32'h1234_5678),
            chk(cdq_pkg::OP_PUSH_REAR,  32'ha5a5_a5a5),
            chk(cdq_pkg::OP_POP_REAR,   32'h0000_0000),
            chk(cdq_pkg::OP_POP_FRONT,  32'h0000_0000),
            chk(cdq_pkg::OP_POP_FRONT,  32'h0000_0000),
            chk(cdq_pkg::OP_POP_REAR,   32'h0000_0000),
            fix(cdq_pkg::OP_POP_REAR,   32'h7fff_ffff, cdq_pkg::ST_UNDERFLOW, '0, 1'b1, 1'b0),
            chk(cdq_pkg::OP_PUSH_REAR,  32'h5a5a_5a5a),
            chk(cdq_pkg::OP_PUSH_REAR,  32'h0000_0001),
            chk(cdq_pkg::OP_POP_FRONT,  32'h0000_0000),
            chk(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0001),
            chk(cdq_pkg::OP_POP_REAR,   32'h0000_0000),
            chk(cdq_pkg::OP_POP_REAR,   32'h0000_0000),
            fix(cdq_pkg::OP_POP_FRONT,  32'h8000_0000, cdq_pkg::ST_UNDERFLOW, '0, 1'b1, 1'b0)
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            issue_op(dir_tbl[i].op, dir_tbl[i].val, dir_tbl[i].fixed, dir_tbl[i].res);

        push_pct = 50;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 40 == 0)
            begin
                burst_mode = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    2: push_pct = 75;
                    default: push_pct = 95;
                endcase
            end
            if (i == RANDOM_OPS / 2)
            begin
                start <= 1'b0;
                @(negedge clk);
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            issue_op(pick_op(push_pct), pick_value(), 1'b0, no_res);
        end

        // drain to empty, then underflow
        while (!sh_empty)
        begin
            burst_mode = ($urandom_range(0, 7) != 0);
            issue_op(pick_op(0), pick_value(), 1'b0, no_res);
        end
        burst_mode = 1'b0;
        for (int i = 0; i < 3; i++)
            issue_op(pick_op(0), pick_value(), 1'b0, no_res);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
